// ===== rtl/lrwg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrwg_pkg
// Shared types and constants of the LCG random word generator.
// ----------------------------------------------------------------------------
package lrwg_pkg;

  // Generator constants: state <- (LcgMul * state + LcgInc) mod 2^31
  localparam int unsigned LcgWidth = 31;
  localparam logic [LcgWidth-1:0] LcgMul = 31'd1103515245;
  localparam logic [LcgWidth-1:0] LcgInc = 31'd12345;

  // Letter scaling: 'a' + ((state * 26) >> 31)
  localparam logic [6:0] LetterBase = 7'd97;
  localparam logic [4:0] LetterSpan = 5'd26;

  // Word length saturation
  localparam int unsigned MaxWordLen = 15;
  localparam int unsigned ResultCap  = 15;
  localparam logic [3:0]  LenCap     = (MaxWordLen < ResultCap) ? 4'(MaxWordLen)
                                                                 : 4'(ResultCap);

  // Command queue default depth
  localparam int unsigned QueueDepth = 2;

  // Operation codes
  localparam logic OpSeed = 1'b0;
  localparam logic OpWord = 1'b1;

  // Configuration register indexes
  localparam logic CfgMinLen = 1'b0;
  localparam logic CfgMaxLen = 1'b1;

  localparam logic [3:0] MinLenReset = 4'd3;
  localparam logic [3:0] MaxLenReset = 4'd10;

  typedef struct packed {
    logic        op;
    logic [30:0] seed_value;
  } in_word_t;

  typedef struct packed {
    logic [6:0] letter;
    logic [3:0] position;
    logic       last;
  } out_word_t;

  // Classified command passed from the front to the back
  typedef struct packed {
    logic        is_word;
    logic [30:0] seed;
    logic [3:0]  lo;
    logic [4:0]  span;
    logic        fixed_len;
  } cmd_t;

  typedef enum logic [1:0] {
    BackIdle,
    BackLenAdv,
    BackLenDraw,
    BackEmit
  } back_state_e;

endpackage

// ===== rtl/lcg_random_word_generator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcg_random_word_generator_core
// Random lowercase word generator on a 31-bit linear congruential generator.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_word_i): op 0 loads seed_value
//   into the generator, op 1 asks for one word. Output channel (out_valid_o /
//   out_stall_i / out_word_o): one word per letter with its position, and
//   last set on the final letter. A zero-length word yields nothing.
//   Config port: cfg_we_i writes cfg_wdata_i to min_len (index 0) or max_len
//   (index 1); write only while the block is idle.
//   Throughput: a seed is loaded as the idle engine pops it; a word passes
//   through the pop, a length advance (only if the bounds differ), the
//   length draw and its letters, paced by the single generator multiplier
//   that steps at most once per cycle and waits while the output stalls.
//   A two-entry command queue lets new input words be taken while a word
//   is still being produced. The first letter is emitted after the draw.
//   Stall: the output register holds its word while out_stall_i is high and
//   the engine waits; the queue then fills and in_stall_o rises.
//   Reset: generator state 0, min_len 3, max_len 10, queue and output empty.
// ----------------------------------------------------------------------------
module lcg_random_word_generator_core #(
  parameter int unsigned QueueDepth = lrwg_pkg::QueueDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_index_i,
  input  logic [3:0]          cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  lrwg_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output lrwg_pkg::out_word_t out_word_o
);

  // front -> queue
  logic           push;
  logic           full;
  lrwg_pkg::cmd_t push_cmd;

  // queue -> back
  logic           pop;
  logic           empty;
  lrwg_pkg::cmd_t pop_cmd;

  // Front: bounds registers, request classification
  lrwg_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_word_i   (in_word_i),
    .in_stall_o  (in_stall_o),
    .full_i      (full),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  // Command queue keeps seeds and words in order
  lrwg_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_cmd),
    .empty_o     (empty)
  );

  // Back: generator state, length draw, letter sequencing, output register
  lrwg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (pop_cmd),
    .cmd_empty_i (empty),
    .cmd_pop_o   (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

// ===== rtl/lrwg_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrwg_front
// Holds the length bounds, accepts input words and turns them into commands.
// ----------------------------------------------------------------------------
module lrwg_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_index_i,
  input  logic [3:0]        cfg_wdata_i,
  input  logic              in_valid_i,
  input  lrwg_pkg::in_word_t in_word_i,
  output logic              in_stall_o,
  input  logic              full_i,
  output logic              push_o,
  output lrwg_pkg::cmd_t    cmd_o
);

  logic [3:0] min_len_q;
  logic [3:0] max_len_q;
  logic [3:0] lo;
  logic [3:0] hi;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_len_q <= lrwg_pkg::MinLenReset;
      max_len_q <= lrwg_pkg::MaxLenReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        lrwg_pkg::CfgMinLen: min_len_q <= cfg_wdata_i;
        lrwg_pkg::CfgMaxLen: max_len_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Reversed bounds are swapped for the draw only
  always_comb begin
    if (min_len_q > max_len_q) begin
      lo = max_len_q;
      hi = min_len_q;
    end else begin
      lo = min_len_q;
      hi = max_len_q;
    end
  end

  always_comb begin
    cmd_o.is_word   = (in_word_i.op == lrwg_pkg::OpWord);
    cmd_o.seed      = in_word_i.seed_value;
    cmd_o.lo        = lo;
    // full range 0..15 needs 16, one bit above the bounds
    cmd_o.span      = {1'b0, hi} - {1'b0, lo} + 5'd1;  // unused when fixed_len
    cmd_o.fixed_len = (lo == hi);
  end

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;

endmodule

// ===== rtl/lrwg_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrwg_fifo
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module lrwg_fifo #(
  parameter int unsigned Depth = lrwg_pkg::QueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  lrwg_pkg::cmd_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output lrwg_pkg::cmd_t pop_data_o,
  output logic           empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  lrwg_pkg::cmd_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push;
  logic            do_pop;

  assign full_o     = (cnt_q == FullCnt);
  assign empty_o    = (cnt_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    if (do_pop)  rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    if (do_push && !do_pop) cnt_d = cnt_q + 1'b1;
    else if (do_pop && !do_push) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule

// ===== rtl/lrwg_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrwg_back
// LCG engine: seed loads and word commands, one generator step a cycle at most.
// ----------------------------------------------------------------------------
module lrwg_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lrwg_pkg::cmd_t      cmd_i,
  input  logic                cmd_empty_i,
  output logic                cmd_pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output lrwg_pkg::out_word_t out_word_o
);

  lrwg_pkg::back_state_e state_q, state_d;

  logic [30:0] lcg_q;
  logic [3:0]  lo_q;
  logic [4:0]  span_q;
  logic        fixed_q;
  logic [3:0]  len_q;
  logic [3:0]  cnt_q;
  logic        out_valid_q;
  lrwg_pkg::out_word_t out_q;

  logic [30:0] mul_lo;
  logic [30:0] lcg_next;
  logic [4:0]  scale_b;
  logic [35:0] scale_prod;
  logic [4:0]  draw;
  logic [3:0]  len_raw;
  logic [3:0]  len_cap;
  logic        out_free;
  logic        is_last;

  // control
  logic load_seed;
  logic latch_cmd;
  logic lcg_step;
  logic start_word;
  logic emit;

  // Generator step, low 31 bits only
  assign mul_lo   = lcg_q * lrwg_pkg::LcgMul;
  assign lcg_next = mul_lo + lrwg_pkg::LcgInc;

  // Shared scaler: length draw or letter draw
  assign scale_b    = (state_q == lrwg_pkg::BackLenDraw) ? span_q
                                                         : lrwg_pkg::LetterSpan;
  assign scale_prod = {5'b0, lcg_q} * {31'b0, scale_b};
  assign draw       = scale_prod[35:31];

  assign len_raw  = fixed_q ? lo_q : lo_q + draw[3:0];
  assign len_cap  = (len_raw > lrwg_pkg::LenCap) ? lrwg_pkg::LenCap : len_raw;
  assign out_free = !out_valid_q || !out_stall_i;
  assign is_last  = (cnt_q == len_q - 4'd1);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lrwg_pkg::BackIdle: begin
        if (!cmd_empty_i && cmd_i.is_word) begin
          state_d = cmd_i.fixed_len ? lrwg_pkg::BackLenDraw : lrwg_pkg::BackLenAdv;
        end
      end
      lrwg_pkg::BackLenAdv:  state_d = lrwg_pkg::BackLenDraw;
      lrwg_pkg::BackLenDraw: state_d = (len_cap == '0) ? lrwg_pkg::BackIdle
                                                       : lrwg_pkg::BackEmit;
      lrwg_pkg::BackEmit: begin
        if (out_free && is_last) state_d = lrwg_pkg::BackIdle;
      end
      default: state_d = lrwg_pkg::BackIdle;
    endcase
  end

  // Control outputs
  always_comb begin
    cmd_pop_o  = 1'b0;
    load_seed  = 1'b0;
    latch_cmd  = 1'b0;
    lcg_step   = 1'b0;
    start_word = 1'b0;
    emit       = 1'b0;
    unique case (state_q)
      lrwg_pkg::BackIdle: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          load_seed = !cmd_i.is_word;
          latch_cmd = cmd_i.is_word;
        end
      end
      lrwg_pkg::BackLenAdv: lcg_step = 1'b1;
      lrwg_pkg::BackLenDraw: begin
        // step for the first letter alongside the length draw
        start_word = (len_cap != '0);
        lcg_step   = (len_cap != '0);
      end
      lrwg_pkg::BackEmit: begin
        emit     = out_free;
        lcg_step = out_free && !is_last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lrwg_pkg::BackIdle;
      lcg_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_seed)     lcg_q <= cmd_i.seed;
      else if (lcg_step) lcg_q <= lcg_next;
      if (emit)              out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (latch_cmd) begin
      lo_q    <= cmd_i.lo;
      span_q  <= cmd_i.span;
      fixed_q <= cmd_i.fixed_len;
    end
    if (start_word) begin
      len_q <= len_cap;
      cnt_q <= '0;
    end else if (emit) begin
      cnt_q <= cnt_q + 4'd1;
    end
    if (emit) begin
      out_q.letter   <= lrwg_pkg::LetterBase + {2'b0, draw};
      out_q.position <= cnt_q;
      out_q.last     <= is_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule
